[rtl/core/chim_pkg.sv]
// Shared types and constants for the chained hash integer map.
package chim_pkg;

    localparam int NUM_BUCKETS_DEF  = 63;
    localparam int POOL_ENTRIES_DEF = 256;
    localparam int VALUE_WIDTH_DEF  = 32;

    localparam int KEY_W   = 31;
    localparam int COUNT_W = 9;

    localparam logic [1:0] OP_SET    = 2'd0;
    localparam logic [1:0] OP_GET    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [1:0] ST_FOUND  = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_INSERT = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    // Folds a signed key to its magnitude, saturating the most negative value.
    function automatic logic [KEY_W-1:0] fold_key(input logic [31:0] raw);
        logic [31:0] neg;
        neg = 32'd0 - raw;
        if (!raw[31]) return raw[KEY_W-1:0];
        if (neg[31]) return {KEY_W{1'b1}};
        return neg[KEY_W-1:0];
    endfunction

endpackage

[rtl/core/chim_front.sv]
// Front end: folds the key and finds its bucket by reciprocal multiplication.
module chim_front #(
    parameter int NUM_BUCKETS = chim_pkg::NUM_BUCKETS_DEF,
    parameter int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [1:0]               i_op,
    input  logic [31:0]              i_key,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [1:0]               o_op,
    output logic [chim_pkg::KEY_W-1:0] o_key,
    output logic [BW-1:0]            o_bucket
);
    import chim_pkg::*;

    // Rounded-up reciprocal of the bucket count; exact for every key of KEY_W bits.
    localparam int LG  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 0;
    localparam int SH  = KEY_W + LG;
    localparam int PRW = 2 * KEY_W + 1;
    localparam logic [KEY_W:0] MAGIC = (KEY_W+1)'(((64'd1 << SH) + 64'(NUM_BUCKETS)
                                       - 64'd1) / 64'(NUM_BUCKETS));

    logic [1:0]       r_op;
    logic [KEY_W-1:0] r_key;
    logic [KEY_W-1:0] r_quot;
    logic [BW-1:0]    r_rem;
    logic             r_busy;
    logic             r_stage;
    logic             r_done;
    logic [PRW-1:0]   n_prod;
    logic [KEY_W-1:0] n_quot;

    assign o_ready  = !r_busy && !r_done;
    assign o_valid  = r_done;
    assign o_op     = r_op;
    assign o_key    = r_key;
    assign o_bucket = r_rem;

    // Quotient from the reciprocal product.
    assign n_prod = {{(KEY_W+1){1'b0}}, r_key} * {{KEY_W{1'b0}}, MAGIC};
    assign n_quot = KEY_W'(n_prod >> SH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_op    <= i_op;
            r_key   <= fold_key(i_key);
            r_stage <= 1'b0;
            r_busy  <= 1'b1;
        end else if (r_busy) begin
            if (!r_stage) begin
                r_quot  <= n_quot;
                r_stage <= 1'b1;
            end else begin
                // The remainder is what the quotient leaves of the key.
                r_rem  <= BW'(r_key - r_quot * KEY_W'(NUM_BUCKETS));
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else if (r_done && i_ready) begin
            r_done <= 1'b0;
        end
    end
endmodule

[rtl/core/chim_queue.sv]
// Two-entry request queue between the front end and the back end.
module chim_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [W-1:0] i_data,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [W-1:0] o_data
);
    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;
    logic         wr;
    logic         rd;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign wr = i_valid && o_ready;
    assign rd = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_data;
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= !r_wp;
            if (rd) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end
endmodule

[rtl/core/chim_back.sv]
// Back end: walks bucket chains in the pool memories and applies each request.
module chim_back #(
    parameter int NUM_BUCKETS  = chim_pkg::NUM_BUCKETS_DEF,
    parameter int POOL_ENTRIES = chim_pkg::POOL_ENTRIES_DEF,
    parameter int VALUE_WIDTH  = chim_pkg::VALUE_WIDTH_DEF,
    parameter int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [1:0]                 i_op,
    input  logic [chim_pkg::KEY_W-1:0] i_key,
    input  logic [BW-1:0]              i_bucket,
    input  logic [VALUE_WIDTH-1:0]     i_value,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [1:0]                 o_status,
    output logic [31:0]                o_value,
    output logic [chim_pkg::COUNT_W-1:0] o_count
);
    import chim_pkg::*;

    localparam int IW = $clog2(POOL_ENTRIES + 1);
    localparam int PW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
    localparam logic [IW-1:0] NULL_IDX = IW'(POOL_ENTRIES);

    typedef enum logic [2:0] {
        S_IDLE, S_HEAD, S_READ, S_CHECK, S_FREE, S_APPLY, S_OUT
    } t_state;

    // Bucket heads: flip-flops with valid bits, empty until first written.
    logic [IW-1:0] r_head  [NUM_BUCKETS];
    logic          r_hval  [NUM_BUCKETS];
    // Pool memories.
    logic [KEY_W-1:0]       m_key  [POOL_ENTRIES];
    logic [VALUE_WIDTH-1:0] m_val  [POOL_ENTRIES];
    logic [IW-1:0]          m_next [POOL_ENTRIES];
    logic [IW-1:0]          m_free [POOL_ENTRIES];
    // Highest held count so far; free-stack slots at or above it have never
    // been written.
    logic [IW-1:0]          r_hwm;

    t_state                 r_state;
    logic [1:0]             r_op;
    logic [KEY_W-1:0]       r_key;
    logic [BW-1:0]          r_bkt;
    logic [VALUE_WIDTH-1:0] r_vin;
    logic [IW-1:0]          r_cur;
    logic [IW-1:0]          r_prev;
    logic [IW:0]            r_steps;
    logic [KEY_W-1:0]       r_rkey;
    logic [VALUE_WIDTH-1:0] r_rval;
    logic [IW-1:0]          r_rnext;
    logic [IW-1:0]          r_fidx;
    logic                   r_hit;
    logic [IW-1:0]          r_held;
    logic [1:0]             r_status;
    logic [31:0]            r_vout;
    logic [IW-1:0]          fslot;

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = (r_state == S_OUT);
    assign o_status = r_status;
    assign o_value  = r_vout;
    assign o_count  = COUNT_W'(r_held);
    assign fslot    = NULL_IDX - r_held - IW'(1);

    // Memory reads, registered.
    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_rkey  <= m_key[r_cur[PW-1:0]];
            r_rval  <= m_val[r_cur[PW-1:0]];
            r_rnext <= m_next[r_cur[PW-1:0]];
        end
        if (r_state == S_FREE)
            r_fidx <= (r_held < r_hwm) ? m_free[fslot[PW-1:0]] : (NULL_IDX - IW'(1) - fslot);
    end

    // Sequencer and all writes to heads, pool memories and counts.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_held  <= '0;
            r_hwm   <= '0;
            for (int b = 0; b < NUM_BUCKETS; b++) r_hval[b] <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_op    <= i_op;
                        r_key   <= i_key;
                        r_bkt   <= i_bucket;
                        r_vin   <= i_value;
                        r_state <= S_HEAD;
                    end
                end
                S_HEAD: begin
                    r_cur   <= r_hval[r_bkt] ? r_head[r_bkt] : NULL_IDX;
                    r_prev  <= NULL_IDX;
                    r_steps <= '0;
                    r_hit   <= 1'b0;
                    r_state <= S_READ;
                end
                S_READ: begin
                    if (r_cur >= NULL_IDX || r_steps >= (IW+1)'(POOL_ENTRIES)) begin
                        r_prev  <= NULL_IDX;
                        r_state <= S_FREE;
                    end else begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_rkey == r_key) begin
                        r_hit   <= 1'b1;
                        r_state <= S_FREE;
                    end else begin
                        r_prev  <= r_cur;
                        r_cur   <= r_rnext;
                        r_steps <= r_steps + (IW+1)'(1);
                        r_state <= S_READ;
                    end
                end
                S_FREE: r_state <= S_APPLY;
                S_APPLY: begin
                    r_status <= ST_ABSENT;
                    r_vout   <= '0;
                    unique case (r_op)
                        OP_SET: begin
                            if (r_hit) begin
                                m_val[r_cur[PW-1:0]] <= r_vin;
                                r_status <= ST_FOUND;
                            end else if (r_held >= NULL_IDX || r_fidx >= NULL_IDX) begin
                                r_status <= ST_FULL;
                            end else begin
                                m_key[r_fidx[PW-1:0]]  <= r_key;
                                m_val[r_fidx[PW-1:0]]  <= r_vin;
                                m_next[r_fidx[PW-1:0]] <=
                                    r_hval[r_bkt] ? r_head[r_bkt] : NULL_IDX;
                                r_head[r_bkt] <= r_fidx;
                                r_hval[r_bkt] <= 1'b1;
                                r_held   <= r_held + IW'(1);
                                if (r_held == r_hwm)
                                    r_hwm <= r_hwm + IW'(1);
                                r_status <= ST_INSERT;
                            end
                        end
                        OP_GET: begin
                            if (r_hit) begin
                                r_vout   <= 32'(r_rval);
                                r_status <= ST_FOUND;
                            end
                        end
                        OP_REMOVE: begin
                            if (r_hit) begin
                                if (r_prev < NULL_IDX) begin
                                    m_next[r_prev[PW-1:0]] <= r_rnext;
                                end else begin
                                    r_head[r_bkt] <= r_rnext;
                                    r_hval[r_bkt] <= 1'b1;
                                end
                                // Push the entry just above the current free top.
                                if (r_held != '0) begin
                                    m_free[PW'(NULL_IDX - r_held)] <= r_cur;
                                    r_held <= r_held - IW'(1);
                                end
                                r_status <= ST_FOUND;
                            end
                        end
                        default: ;
                    endcase
                    r_state <= S_OUT;
                end
                S_OUT: if (i_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

[rtl/core/chained_hash_int_map.sv]
// Top level of the chained hash integer map.
//
// Channel   Direction  tdata fields (low bit up)           tuser
// s_axis    in         key[31:0], value_in[63:32]          opcode[1:0]
// m_axis    out        value_out[31:0], entry_count[40:32] status[1:0]
//
// The front end registers the folded key, forms the quotient by reciprocal
// multiplication and then the bucket by multiply and subtract; it takes a new
// transaction only once the last one has been handed to the queue. The back end
// reads the bucket head, reads and checks each chain entry walked, fetches a
// free slot, applies the request and holds the result until it is taken.
// The two overlap through a two-entry queue.
// Reset is synchronous and active low and clears heads, free stack and count.
// A stalled result holds the back end; the front end keeps working until the queue is full.
module chained_hash_int_map #(
    parameter int NUM_BUCKETS  = chim_pkg::NUM_BUCKETS_DEF,
    parameter int POOL_ENTRIES = chim_pkg::POOL_ENTRIES_DEF,
    parameter int VALUE_WIDTH  = chim_pkg::VALUE_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // key[31:0], value_in[63:32]
    input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // value_out[31:0], entry_count[40:32]
    output logic [1:0]  m_axis_tuser    // status[1:0]
);
    import chim_pkg::*;

    localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int QW = 2 + KEY_W + BW + VALUE_WIDTH;

    logic                   f_valid, f_ready, q_valid, q_ready;
    logic [1:0]             f_op, q_op;
    logic [KEY_W-1:0]       f_key, q_key;
    logic [BW-1:0]          f_bkt, q_bkt;
    logic [VALUE_WIDTH-1:0] r_fval, q_val;
    logic [QW-1:0]          q_in, q_out;
    logic [1:0]             b_status;
    logic [31:0]            b_value;
    logic [COUNT_W-1:0]     b_count;

    // Value rides alongside the front end.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready)
            r_fval <= VALUE_WIDTH'(s_axis_tdata[63:32]);
    end

    chim_front #(.NUM_BUCKETS(NUM_BUCKETS)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_op(s_axis_tuser), .i_key(s_axis_tdata[31:0]),
        .o_valid(f_valid), .i_ready(f_ready),
        .o_op(f_op), .o_key(f_key), .o_bucket(f_bkt)
    );

    assign q_in = {f_op, f_key, f_bkt, r_fval};
    assign {q_op, q_key, q_bkt, q_val} = q_out;

    chim_queue #(.W(QW)) u_queue (
        .i_clk, .i_rst_n,
        .i_valid(f_valid), .o_ready(f_ready), .i_data(q_in),
        .o_valid(q_valid), .i_ready(q_ready), .o_data(q_out)
    );

    chim_back #(
        .NUM_BUCKETS(NUM_BUCKETS), .POOL_ENTRIES(POOL_ENTRIES),
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_back (
        .i_clk, .i_rst_n,
        .i_valid(q_valid), .o_ready(q_ready),
        .i_op(q_op), .i_key(q_key), .i_bucket(q_bkt), .i_value(q_val),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_status(b_status), .o_value(b_value), .o_count(b_count)
    );

    assign m_axis_tdata = {7'd0, b_count, b_value};
    assign m_axis_tuser = b_status;

    // A result never claims more entries than the pool holds.
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (b_count <= COUNT_W'(POOL_ENTRIES)))
        else $error("entry count above pool size");

    // Only a successful get returns a nonzero value.
    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && b_status != ST_FOUND) |-> (b_value == 32'd0))
        else $error("value on non-found result");

    // A stalled result holds steady.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed under stall");
endmodule

[verif/chained_hash_int_map_tb.sv]
// Testbench for the chained hash integer map: directed and random requests checked against a predictor.
`timescale 1ns / 1ps

module chained_hash_int_map_tb;
    import chim_pkg::*;

    localparam int NB = NUM_BUCKETS_DEF;
    localparam int NP = POOL_ENTRIES_DEF;
    localparam int CYCLE_LIMIT = 2000000;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] value_out;
        logic [8:0]  entry_count;
    } t_map_answer;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;   // key[31:0], value_in[63:32]
    logic [1:0]  s_axis_tuser = '0;   // opcode[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;        // value_out[31:0], entry_count[40:32]
    logic [1:0]  m_axis_tuser;        // status[1:0]

    chained_hash_int_map dut (.*);

    always #2 i_clk = ~i_clk;

    // Predictor state: an associative view of the map is enough, since order
    // within a chain never shows at the outputs.
    logic [31:0] held_values [int unsigned];
    int unsigned live_keys[$];
    t_map_answer answer_queue[$];
    int fail_count = 0;
    int answer_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off_cycles = 0;

    // Magnitude of a signed key, saturating the most negative value.
    function automatic int unsigned key_magnitude(input logic [31:0] raw);
        logic [31:0] neg;
        neg = 32'd0 - raw;
        if (!raw[31]) return raw;
        if (neg[31]) return 32'h7FFF_FFFF;
        return neg;
    endfunction

    // Apply one request to the predicted map and queue its answer.
    task automatic predict_request(input logic [1:0] op, input logic [31:0] key,
                                   input logic [31:0] val);
        int unsigned mag;
        t_map_answer ans;
        mag = key_magnitude(key);
        ans = '{status: ST_ABSENT, value_out: 32'd0, entry_count: 9'd0};
        if (op == OP_SET) begin
            if (held_values.exists(mag)) begin
                held_values[mag] = val;
                ans.status = ST_FOUND;
            end else if (held_values.num() >= NP) begin
                ans.status = ST_FULL;
            end else begin
                held_values[mag] = val;
                live_keys.push_back(mag);
                ans.status = ST_INSERT;
            end
        end else if (op == OP_GET) begin
            if (held_values.exists(mag)) begin
                ans.status = ST_FOUND;
                ans.value_out = held_values[mag];
            end
        end else if (op == OP_REMOVE) begin
            if (held_values.exists(mag)) begin
                held_values.delete(mag);
                foreach (live_keys[i])
                    if (live_keys[i] == mag) begin
                        live_keys.delete(i);
                        break;
                    end
                ans.status = ST_FOUND;
            end
        end
        ans.entry_count = 9'(held_values.num());
        answer_queue.push_back(ans);
    endtask

    // Send one request and wait until it is accepted; valid stays up so that
    // the next request can follow directly.
    task automatic send_request(input logic [1:0] op, input logic [31:0] key,
                                input logic [31:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {val, key};
        predict_request(op, key, val);
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on answer %0d: %s got %0h expected %0h",
                 answer_count, what, got, want);
        fail_count++;
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (answer_queue.size() == 0) begin
                report_mismatch("unexpected result", 32'(m_axis_tuser), 32'd0);
            end else begin
                t_map_answer want;
                want = answer_queue.pop_front();
                if (m_axis_tuser != want.status)
                    report_mismatch("status", 32'(m_axis_tuser), 32'(want.status));
                if (m_axis_tdata[31:0] != want.value_out)
                    report_mismatch("value_out", m_axis_tdata[31:0], want.value_out);
                if (m_axis_tdata[40:32] != want.entry_count)
                    report_mismatch("entry_count", 32'(m_axis_tdata[40:32]),
                                    32'(want.entry_count));
                if (m_axis_tdata[47:41] != 7'd0)
                    report_mismatch("tdata padding", 32'(m_axis_tdata[47:41]), 32'd0);
            end
            answer_count++;
        end
    end

    // Receiver readiness, with an optional long hold-off.
    always @(posedge i_clk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Cycle limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Random key: mostly reused or small, otherwise any 32-bit value.
    function automatic logic [31:0] pick_key();
        int sel;
        logic [31:0] k;
        sel = $urandom_range(99);
        if (sel < 40 && live_keys.size() > 0) begin
            k = live_keys[$urandom_range(live_keys.size() - 1)];
            if ($urandom_range(1)) k = 32'd0 - k;
        end else if (sel < 75) begin
            k = $urandom_range(400);
            if ($urandom_range(1)) k = 32'd0 - k;
        end else begin
            k = $urandom;
        end
        return k;
    endfunction

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (answer_queue.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic run_random(input int count, input int set_pct, input int get_pct);
        int r;
        logic [1:0] op;
        repeat (count) begin
            r = $urandom_range(99);
            if (r < set_pct) op = OP_SET;
            else if (r < set_pct + get_pct) op = OP_GET;
            else if (r < 97) op = OP_REMOVE;
            else op = OP_UNUSED;
            send_request(op, pick_key(), $urandom);
        end
    endtask

    // Extremes of key and value, every opcode, the saturated negative key.
    task automatic test_directed();
        send_request(OP_GET, 32'd0, 32'd0);
        send_request(OP_SET, 32'd0, 32'hFFFF_FFFF);
        send_request(OP_GET, 32'd0, 32'd0);
        send_request(OP_SET, 32'h7FFF_FFFF, 32'h1234_5678);
        send_request(OP_GET, 32'h8000_0000, 32'hFFFF_FFFF);
        send_request(OP_GET, 32'h8000_0001, 32'd0);
        send_request(OP_SET, 32'hFFFF_FFFF, 32'hA5A5_A5A5);
        send_request(OP_GET, 32'd1, 32'd0);
        send_request(OP_SET, 32'd64, 32'd7);
        send_request(OP_SET, 32'd127, 32'd8);
        send_request(OP_GET, 32'd64, 32'd0);
        send_request(OP_REMOVE, 32'd1, 32'd0);
        send_request(OP_REMOVE, 32'd1, 32'd0);
        send_request(OP_REMOVE, 32'd127, 32'd0);
        send_request(OP_GET, 32'd64, 32'd0);
        send_request(OP_UNUSED, 32'd64, 32'hFFFF_FFFF);
        send_request(OP_REMOVE, 32'h8000_0000, 32'd0);
        send_request(OP_SET, 32'd64, 32'd0);
        send_request(OP_GET, 32'd64, 32'd0);
        wait_drained();
    endtask

    // Fill the pool, hit the full case, then drain it again.
    task automatic test_pool_full();
        int unsigned base;
        base = 1000;
        while (held_values.num() < NP) begin
            send_request(OP_SET, base, $urandom);
            base += 63;
        end
        send_request(OP_SET, 32'd5, 32'd1);
        send_request(OP_SET, 32'hFFFF_FFFB, 32'd2);
        send_request(OP_SET, 32'd1000, 32'd3);
        send_request(OP_GET, 32'd1000, 32'd0);
        run_random(40, 30, 40);
        while (live_keys.size() > 0)
            send_request(OP_REMOVE, live_keys[0], $urandom);
        wait_drained();
    endtask

    // Long receiver hold-off while requests keep coming.
    task automatic test_back_pressure();
        hold_off_cycles = 600;
        run_random(30, 50, 30);
        wait_drained();
    endtask

    task automatic test_random_phases();
        send_idle_pct = 0;  recv_stall_pct = 0;  run_random(85, 50, 30); wait_drained();
        send_idle_pct = 62; recv_stall_pct = 0;  run_random(85, 45, 35); wait_drained();
        send_idle_pct = 0;  recv_stall_pct = 62; run_random(85, 40, 35); wait_drained();
        send_idle_pct = 8;  recv_stall_pct = 8;  run_random(85, 50, 30); wait_drained();
        send_idle_pct = 0;  recv_stall_pct = 0;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_pool_full();
        test_back_pressure();
        test_random_phases();
        $display("Covered all opcodes, key extremes, pool full, a long output stall,");
        $display("and random traffic under four idle mixes: %0d results checked.",
                 answer_count);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[chained_hash_int_map.f]
rtl/core/chim_pkg.sv
rtl/core/chim_front.sv
rtl/core/chim_queue.sv
rtl/core/chim_back.sv
rtl/core/chained_hash_int_map.sv
verif/chained_hash_int_map_tb.sv
